// ===== hw/rtl/ipwm_pkg.sv =====
// Package for the IUPAC probe window matcher: sizes, codes and the pair-match function.
// Used by every file under hw/rtl; depends on nothing.
`default_nettype none
package ipwm_pkg;
    localparam int NUM_PROBES    = 8;
    localparam int MAX_PROBE_LEN = 32;
    localparam int PSEL_W  = 3;
    localparam int POFF_W  = 5;
    localparam int LEN_W   = 6;
    localparam int PADDR_W = PSEL_W + POFF_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NFILTER   = 1'd1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_GENOME = 2'd1,
        OP_RECORD = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_SCORE,
        ST_DIV,
        ST_EMIT,
        ST_WAIT
    } state_t;

    // Commands from the sequencer to the scoring unit.
    typedef struct packed {
        logic             clear;
        logic             step;
        logic [POFF_W-1:0] j;
    } score_ctl_t;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_N = 8'h4E;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A)
            return c - 8'd32;
        return c;
    endfunction

    function automatic logic [3:0] base_set(input logic [7:0] c);
        unique case (c)
            8'h41: return 4'b0001;
            8'h43: return 4'b0010;
            8'h47: return 4'b0100;
            8'h54: return 4'b1000;
            8'h59: return 4'b1010;
            8'h52: return 4'b0101;
            8'h4D: return 4'b0011;
            8'h4B: return 4'b1100;
            8'h53: return 4'b0110;
            8'h57: return 4'b1001;
            8'h48: return 4'b1011;
            8'h42: return 4'b1110;
            8'h56: return 4'b0111;
            8'h44: return 4'b1101;
            default: return 4'b0000;
        endcase
    endfunction

    function automatic logic is_plain(input logic [7:0] c);
        return c == CH_A || c == CH_C || c == CH_G || c == CH_T;
    endfunction

    function automatic logic pair_score(input logic [7:0] g, input logic [7:0] q);
        logic lg, lq;
        lg = g >= 8'h41 && g <= 8'h5A;
        lq = q >= 8'h41 && q <= 8'h5A;
        if (!lg || !lq)
            return 1'b0;
        if (g == q || g == CH_N || q == CH_N)
            return 1'b1;
        if (is_plain(g) && (base_set(q) & base_set(g)) != 4'b0)
            return 1'b1;
        if (is_plain(q) && (base_set(g) & base_set(q)) != 4'b0)
            return 1'b1;
        return 1'b0;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ipwm_if.sv =====
// Valid/ready channel interfaces for the probe window matcher.
// Depends on ipwm_pkg for field widths.
`default_nettype none
interface ipwm_in_if;
    import ipwm_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [PSEL_W-1:0]   probe_select;
    logic [POFF_W-1:0]   probe_offset;
    logic                probe_end;
    logic [7:0]          symbol;
    modport source (output valid, operation, probe_select, probe_offset, probe_end, symbol,
                    input ready);
    modport sink (input valid, operation, probe_select, probe_offset, probe_end, symbol,
                  output ready);
endinterface

interface ipwm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hit_position;
    logic [31:0] hit_distance;
    logic [2:0]  hit_probe;
    logic [6:0]  match_percent;
    logic        last_hit;
    modport source (output valid, hit_position, hit_distance, hit_probe, match_percent,
                    last_hit, input ready);
    modport sink (input valid, hit_position, hit_distance, hit_probe, match_percent,
                  last_hit, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ipwm_score.sv =====
// Shared scoring unit: one window/probe symbol pair a cycle, then a restoring divider.
// Depends on ipwm_pkg.
`default_nettype none
module ipwm_score
    import ipwm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire score_ctl_t       ctl,
    input  wire logic [7:0]       gsym,
    input  wire logic [7:0]       psym,
    input  wire logic             div_start,
    input  wire logic [LEN_W-1:0] len,
    output logic                  div_done,
    output logic [6:0]            pct,
    output logic                  any_n,
    output logic                  all_n
);
    logic [LEN_W-1:0]  score_reg, score_next;
    logic              any_n_reg, any_n_next, all_n_reg, all_n_next;
    // Dividend score*100 fits 13 bits; quotient at most 100.
    logic [12:0]       rem_reg, rem_next;
    logic [12:0]       quo_reg, quo_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [13:0]       trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        any_n_reg <= any_n_next;
        all_n_reg <= all_n_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    always_comb
    begin
        score_next = score_reg;
        any_n_next = any_n_reg;
        all_n_next = all_n_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        div_done   = 1'b0;
        trial      = '0;
        if (ctl.clear)
        begin
            score_next = '0;
            any_n_next = 1'b0;
            all_n_next = 1'b1;
        end
        else if (ctl.step)
        begin
            score_next = score_reg + LEN_W'(pair_score(gsym, psym));
            if (gsym == CH_N)
                any_n_next = 1'b1;
            else
                all_n_next = 1'b0;
        end
        if (div_start)
        begin
            // score*100 = score*64 + score*32 + score*4
            quo_next  = ({7'd0, score_reg} << 6) + ({7'd0, score_reg} << 5)
                      + ({7'd0, score_reg} << 2);
            rem_next  = '0;
            cnt_next  = 4'd13;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, quo_reg[12]} - {8'd0, len};
            if (!trial[13])
                rem_next = trial[12:0];
            else
                rem_next = {rem_reg[11:0], quo_reg[12]};
            quo_next = {quo_reg[11:0], ~trial[13]};
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                div_done  = 1'b1;
            end
        end
    end

    // The quotient is complete in the cycle that flags div_done.
    assign pct   = quo_next[6:0];
    assign any_n = any_n_reg;
    assign all_n = all_n_reg;

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 4'd0 || $past(div_start)) else $error("divider count");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> busy_reg) else $error("done while idle");
    a_start_stop: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> busy_reg) else $error("divider not started");
endmodule
`default_nettype wire

// ===== hw/rtl/iupac_probe_window_matcher_core.sv =====
// Top level of the IUPAC probe window matcher: probe memory, window, sequencer.
// Depends on ipwm_pkg, ipwm_if and ipwm_score.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | operation, probe_select, probe_offset, probe_end, symbol
//  out_ch   | out | valid/ready   | hit_position, hit_distance, hit_probe, match_percent, last_hit
//  cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// A load, record start or ignored item goes through the wait state back to idle, as
// does a genome symbol while fewer symbols than the longest probe length are held.
// Otherwise a genome symbol walks the probes in turn: an unused probe is skipped,
// a loaded one takes a setup step, len+1 memory reads, a start step and a 13-step
// divider, and each result is held in the emit state until out_ch.ready.
// Reset clears the window, lengths and counters; the probe memory is not cleared.
// The block takes no request while an item is in progress.
`default_nettype none
module iupac_probe_window_matcher_core
    import ipwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ipwm_in_if.sink                    in_ch,
    ipwm_out_if.source                 out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    state_t state_reg, state_next;
    logic [6:0] thr_reg;
    logic [1:0] nf_reg;

    logic [7:0]       pmem [NUM_PROBES*MAX_PROBE_LEN];
    logic [7:0]       prd_reg;
    logic [LEN_W-1:0] plen_reg [NUM_PROBES];
    logic [LEN_W-1:0] longest_reg, longest_next;
    logic [7:0]       win_reg [MAX_PROBE_LEN];
    logic [LEN_W-1:0] fill_reg;
    logic [31:0]      wpos_reg, prev_reg, prev_next;
    logic [PSEL_W-1:0] p_reg, p_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic [PSEL_W:0]   pc_reg, pc_next;   // probe scan counter, reaches NUM_PROBES
    logic              found_reg, found_next;

    logic [31:0] pos;
    logic        accept, do_shift, do_load, do_rec;
    logic [7:0]  sym_in;
    logic [PADDR_W-1:0] raddr;
    logic [7:0]  gsym;
    score_ctl_t  sctl;
    logic        div_start, div_done, any_n, all_n;
    logic [6:0]  pct;
    logic        ovalid_reg, ovalid_next, olast_reg, olast_next;
    logic [31:0] opos_reg, opos_next, odist_reg, odist_next;
    logic [2:0]  oprobe_reg, oprobe_next;
    logic [6:0]  opct_reg, opct_next;
    logic        is_hit, emit, more;
    logic [LEN_W-1:0] len_cur;

    assign accept = in_ch.valid && in_ch.ready;
    assign sym_in = fold_upper(in_ch.symbol);
    assign in_ch.ready = state_reg == ST_IDLE;
    assign do_load = accept && in_ch.operation == OP_LOAD;
    assign do_shift = accept && in_ch.operation == OP_GENOME;
    assign do_rec = accept && in_ch.operation == OP_RECORD;
    assign pos = wpos_reg - {26'd0, longest_reg} + 32'd1;
    assign len_cur = plen_reg[p_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 7'd100;
            nf_reg  <= 2'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_reg <= cfg_data;
                CFG_NFILTER:   nf_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Probe memory: one write port for loads, one registered read port for scoring.
    assign raddr = {p_reg, j_reg[POFF_W-1:0]};
    always_ff @(posedge clk)
    begin
        if (do_load)
            pmem[{in_ch.probe_select, in_ch.probe_offset}] <= sym_in;
        prd_reg <= pmem[raddr];
    end

    always_comb
    begin
        longest_next = '0;
        for (int i = 0; i < NUM_PROBES; i++)
        begin
            if (plen_reg[i] > longest_next)
                longest_next = plen_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PROBES; i++)
                plen_reg[i] <= '0;
            for (int i = 0; i < MAX_PROBE_LEN; i++)
                win_reg[i] <= '0;
            longest_reg <= '0;
            fill_reg    <= '0;
            wpos_reg    <= '0;
            prev_reg    <= '0;
            state_reg   <= ST_IDLE;
            p_reg       <= '0;
            j_reg       <= '0;
            pc_reg      <= '0;
            found_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            p_reg      <= p_next;
            j_reg      <= j_next;
            pc_reg     <= pc_next;
            found_reg  <= found_next;
            ovalid_reg <= ovalid_next;
            prev_reg   <= prev_next;
            longest_reg <= longest_next;
            if (do_load && in_ch.probe_end)
                plen_reg[in_ch.probe_select] <= {1'b0, in_ch.probe_offset} + LEN_W'(1);
            if (do_rec)
            begin
                for (int i = 0; i < MAX_PROBE_LEN; i++)
                    win_reg[i] <= '0;
                fill_reg <= '0;
                wpos_reg <= '0;
            end
            else if (do_shift)
            begin
                win_reg[0] <= sym_in;
                for (int i = 1; i < MAX_PROBE_LEN; i++)
                    win_reg[i] <= win_reg[i-1];
                if (fill_reg != LEN_W'(MAX_PROBE_LEN))
                    fill_reg <= fill_reg + LEN_W'(1);
                if (wpos_reg != 32'hFFFF_FFFF)
                    wpos_reg <= wpos_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        opos_reg   <= opos_next;
        odist_reg  <= odist_next;
        oprobe_reg <= oprobe_next;
        opct_reg   <= opct_next;
        olast_reg  <= olast_next;
    end

    // Window symbol for the pair being scored; the read data follows its address by one register.
    logic [LEN_W-1:0] widx;
    logic [LEN_W-1:0] jd_reg;
    always_ff @(posedge clk)
        jd_reg <= j_reg;
    assign widx = longest_reg - LEN_W'(1) - jd_reg;
    assign gsym = win_reg[widx[POFF_W-1:0]];

    assign is_hit = pct >= thr_reg;
    always_comb
    begin
        unique case (nf_reg)
            2'd0: emit = !any_n;
            2'd1: emit = !all_n;
            default: emit = 1'b1;
        endcase
    end

    // Mask term for the last-result mark.
    logic later_hit_possible;
    assign later_hit_possible = 1'b0;

    always_comb
    begin
        state_next  = state_reg;
        p_next      = p_reg;
        j_next      = j_reg;
        pc_next     = pc_reg;
        found_next  = found_reg;
        prev_next   = prev_reg;
        ovalid_next = ovalid_reg;
        opos_next   = opos_reg;
        odist_next  = odist_reg;
        oprobe_next = oprobe_reg;
        opct_next   = opct_reg;
        olast_next  = olast_reg;
        sctl        = '{clear: 1'b0, step: 1'b0, j: j_reg[POFF_W-1:0]};
        div_start   = 1'b0;
        more        = 1'b0;
        if (do_rec)
            prev_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_shift)
                begin
                    state_next = ST_WAIT;
                    p_next     = '0;
                    pc_next    = '0;
                    found_next = 1'b0;
                end
                else if (accept)
                begin
                    // Mark the scan as finished so that no probe is scored.
                    state_next = ST_WAIT;
                    pc_next    = (PSEL_W+1)'(NUM_PROBES);
                end
            end
            ST_WAIT:
            begin
                // The window and length updates from the request are now visible.
                if (pc_reg == (PSEL_W+1)'(NUM_PROBES) || longest_reg == '0
                    || fill_reg < longest_reg)
                    state_next = ST_IDLE;
                else
                    state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (pc_reg == (PSEL_W+1)'(NUM_PROBES))
                    state_next = ST_IDLE;
                else if (len_cur == '0)
                begin
                    p_next  = p_reg + PSEL_W'(1);
                    pc_next = pc_reg + (PSEL_W+1)'(1);
                end
                else
                begin
                    sctl.clear = 1'b1;
                    j_next     = '0;
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                // Address j issued this cycle; the pair j-1 is scored.
                if (j_reg != '0)
                    sctl.step = 1'b1;
                if (j_reg == len_cur)
                begin
                    state_next = ST_DIV;
                    div_start  = 1'b0;
                end
                else
                    j_next = j_reg + LEN_W'(1);
            end
            ST_DIV:
            begin
                if (j_reg != '0)
                begin
                    div_start = 1'b1;
                    j_next    = '0;
                end
                else if (div_done)
                begin
                    p_next  = p_reg + PSEL_W'(1);
                    pc_next = pc_reg + (PSEL_W+1)'(1);
                    state_next = ST_PROBE;
                    if (is_hit)
                    begin
                        prev_next = pos;
                        if (emit)
                        begin
                            // Previous result now known not to be last; release it.
                            if (found_reg)
                            begin
                                ovalid_next = 1'b1;
                                olast_next  = 1'b0;
                                state_next  = ST_EMIT;
                                more        = 1'b1;
                            end
                            found_next  = 1'b1;
                            opos_next   = pos;
                            odist_next  = (prev_reg == '0 || pos < prev_reg) ? 32'd0
                                        : pos - prev_reg;
                            oprobe_next = 3'(p_reg);
                            opct_next   = pct;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    ovalid_next = 1'b0;
                    state_next  = olast_reg ? ST_IDLE : ST_PROBE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // At the end of the probe scan the held result goes out as the last one.
        if (state_reg == ST_PROBE && pc_reg == (PSEL_W+1)'(NUM_PROBES) && found_reg)
        begin
            ovalid_next = 1'b1;
            olast_next  = 1'b1;
            found_next  = 1'b0;
            state_next  = ST_EMIT;
        end
    end

    // The result register holds one pending hit; a finished result is sent from a
    // shadow copy so that the new pending one can be stored meanwhile.
    logic [31:0] spos_reg, sdist_reg;
    logic [2:0]  sprobe_reg;
    logic [6:0]  spct_reg;
    always_ff @(posedge clk)
    begin
        if (more || (state_reg == ST_PROBE && pc_reg == (PSEL_W+1)'(NUM_PROBES)))
        begin
            spos_reg   <= opos_reg;
            sdist_reg  <= odist_reg;
            sprobe_reg <= oprobe_reg;
            spct_reg   <= opct_reg;
        end
    end

    assign out_ch.valid         = ovalid_reg && state_reg == ST_EMIT;
    assign out_ch.hit_position  = spos_reg;
    assign out_ch.hit_distance  = sdist_reg;
    assign out_ch.hit_probe     = sprobe_reg;
    assign out_ch.match_percent = spct_reg;
    assign out_ch.last_hit      = olast_reg && !later_hit_possible;

    ipwm_score u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sctl),
        .gsym      (gsym),
        .psym      (prd_reg),
        .div_start (div_start),
        .len       (len_cur),
        .div_done  (div_done),
        .pct       (pct),
        .any_n     (any_n),
        .all_n     (all_n)
    );

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready) else $error("accepted while busy");
    a_out_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("result outside emit");
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LEN_W'(MAX_PROBE_LEN)) else $error("fill overflow");
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for iupac_probe_window_matcher_core: IUPAC probe loads,
// genome scans and register settings are predicted in the bench and every hit is checked.
// Depends on ipwm_pkg and ipwm_if from hw/rtl.
`default_nettype none
module tb;
    import ipwm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int LONG_HOLD      = 300;

    typedef struct {
        op_t        op;
        logic [2:0] sel;
        logic [4:0] off;
        logic       last;
        logic [7:0] sym;
        int         gap;
    } scan_req_t;

    typedef struct {
        logic [31:0] position;
        logic [31:0] distance;
        logic [2:0]  probe;
        logic [6:0]  percent;
        logic        last;
    } probe_hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ipwm_in_if  in_ch();
    ipwm_out_if out_ch();

    iupac_probe_window_matcher_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    scan_req_t  req_queue[$];
    probe_hit_t hit_queue[$];
    int error_count = 0;
    int gap_max = 18;
    int stall_max = 18;
    int hold_grants = 0;

    // Bench copy of the block state.
    logic [7:0] probe_mem [0:255];
    logic [5:0] probe_len [0:7];
    logic [5:0] longest;
    logic [7:0] window [0:31];
    logic [5:0] fill;
    logic [31:0] win_pos;
    logic [31:0] prev_hit;
    logic [6:0] threshold_reg;
    logic [1:0] nfilter_reg;

    // Generator bookkeeping so that no unwritten probe symbol is ever scored.
    bit written [0:7][0:31];

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d", field, got, want);
        error_count++;
    endtask

    function automatic logic [3:0] iupac_bases(input logic [7:0] c);
        case (c)
            "A": return 4'b0001;
            "C": return 4'b0010;
            "G": return 4'b0100;
            "T": return 4'b1000;
            "R": return 4'b0101;
            "Y": return 4'b1010;
            "M": return 4'b0011;
            "K": return 4'b1100;
            "S": return 4'b0110;
            "W": return 4'b1001;
            "H": return 4'b1011;
            "B": return 4'b1110;
            "V": return 4'b0111;
            "D": return 4'b1101;
            default: return 4'b0000;
        endcase
    endfunction

    function automatic bit symbols_match(input logic [7:0] g, input logic [7:0] q);
        bit g_plain, q_plain;
        g_plain = (iupac_bases(g) != 0) && ($countones(iupac_bases(g)) == 1);
        q_plain = (iupac_bases(q) != 0) && ($countones(iupac_bases(q)) == 1);
        if (!(g >= "A" && g <= "Z") || !(q >= "A" && q <= "Z"))
            return 1'b0;
        if (g == q || g == "N" || q == "N")
            return 1'b1;
        return (g_plain || q_plain) && ((iupac_bases(g) & iupac_bases(q)) != 0);
    endfunction

    task automatic clear_record();
        for (int k = 0; k < 32; k++)
            window[k] = 8'h00;
        fill = '0;
        win_pos = '0;
        prev_hit = '0;
    endtask

    task automatic predict_hits(input op_t op, input logic [2:0] sel, input logic [4:0] off,
                                input logic last, input logic [7:0] raw);
        logic [7:0] sym;
        logic [31:0] start;
        logic [31:0] hit_dist;
        int span, len, score, pct;
        bit any_n, all_n, emit;
        probe_hit_t found[$];
        probe_hit_t h;
        sym = (raw >= "a" && raw <= "z") ? raw - 8'd32 : raw;
        if (op == OP_LOAD) begin
            probe_mem[{sel, off}] = sym;
            if (last) begin
                probe_len[sel] = off + 6'd1;
                longest = '0;
                for (int p = 0; p < 8; p++)
                    if (probe_len[p] > longest)
                        longest = probe_len[p];
            end
        end else if (op == OP_RECORD) begin
            clear_record();
        end else if (op == OP_GENOME) begin
            for (int k = 31; k > 0; k--)
                window[k] = window[k-1];
            window[0] = sym;
            if (fill < 32)
                fill++;
            if (win_pos != 32'hFFFF_FFFF)
                win_pos++;
            span = int'(longest);
            if (span != 0 && fill >= span) begin
                start = win_pos - 32'(span) + 32'd1;
                for (int p = 0; p < 8; p++) begin
                    len = int'(probe_len[p]);
                    if (len == 0)
                        continue;
                    score = 0;
                    any_n = 1'b0;
                    all_n = 1'b1;
                    for (int j = 0; j < len; j++) begin
                        score += symbols_match(window[span-1-j], probe_mem[p*32+j]);
                        if (window[span-1-j] == "N")
                            any_n = 1'b1;
                        else
                            all_n = 1'b0;
                    end
                    pct = score * 100 / len;
                    if (pct < threshold_reg)
                        continue;
                    if (prev_hit == 0)
                        prev_hit = start;
                    hit_dist = (start >= prev_hit) ? start - prev_hit : 32'd0;
                    prev_hit = start;
                    case (nfilter_reg)
                        2'd0: emit = !any_n;
                        2'd1: emit = !all_n;
                        default: emit = 1'b1;
                    endcase
                    if (!emit)
                        continue;
                    h.position = start;
                    h.distance = hit_dist;
                    h.probe = 3'(p);
                    h.percent = 7'(pct);
                    h.last = 1'b0;
                    found.push_back(h);
                end
                if (found.size() > 0)
                    found[found.size()-1].last = 1'b1;
                foreach (found[i])
                    hit_queue.push_back(found[i]);
            end
        end
    endtask

    // Request driver.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n) begin
        scan_req_t r;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.operation <= OP_NONE;
            in_ch.probe_select <= '0;
            in_ch.probe_offset <= '0;
            in_ch.probe_end <= 1'b0;
            in_ch.symbol <= '0;
            send_gap <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the offered request
        end else if (send_gap > 0) begin
            in_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (req_queue.size() > 0) begin
            r = req_queue.pop_front();
            in_ch.valid <= 1'b1;
            in_ch.operation <= r.op;
            in_ch.probe_select <= r.sel;
            in_ch.probe_offset <= r.off;
            in_ch.probe_end <= r.last;
            in_ch.symbol <= r.sym;
            send_gap <= r.gap;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
        if (rst_n && in_ch.valid && in_ch.ready)
            predict_hits(op_t'(in_ch.operation), in_ch.probe_select, in_ch.probe_offset,
                         in_ch.probe_end, in_ch.symbol);

    // Result monitor with random stalls and a single long hold-off.
    int stall_left = 0;
    int hold_left = 0;
    int hold_taken = 0;
    always @(posedge clk or negedge rst_n) begin
        probe_hit_t want;
        int stall_next;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else begin
            stall_next = stall_left;
            if (out_ch.valid && out_ch.ready) begin
                stall_next = $urandom_range(0, stall_max);
                if (hit_queue.size() == 0) begin
                    report_mismatch("unexpected hit_position", out_ch.hit_position, 0);
                end else begin
                    want = hit_queue.pop_front();
                    if (out_ch.hit_position !== want.position)
                        report_mismatch("hit_position", out_ch.hit_position, want.position);
                    if (out_ch.hit_distance !== want.distance)
                        report_mismatch("hit_distance", out_ch.hit_distance, want.distance);
                    if (out_ch.hit_probe !== want.probe)
                        report_mismatch("hit_probe", out_ch.hit_probe, want.probe);
                    if (out_ch.match_percent !== want.percent)
                        report_mismatch("match_percent", out_ch.match_percent, want.percent);
                    if (out_ch.last_hit !== want.last)
                        report_mismatch("last_hit", out_ch.last_hit, want.last);
                end
            end
            if (hold_taken != hold_grants) begin
                hold_taken <= hold_grants;
                hold_left <= LONG_HOLD;
                stall_left <= stall_next;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                stall_left <= stall_next;
                out_ch.ready <= 1'b0;
            end else if (stall_next > 0) begin
                stall_left <= stall_next - 1;
                out_ch.ready <= 1'b0;
            end else begin
                stall_left <= 0;
                out_ch.ready <= 1'b1;
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic push_req(input op_t op, input logic [2:0] sel, input logic [4:0] off,
                            input logic last, input logic [7:0] sym);
        scan_req_t r;
        r.op = op;
        r.sel = sel;
        r.off = off;
        r.last = last;
        r.sym = sym;
        r.gap = $urandom_range(0, gap_max);
        if (op == OP_LOAD)
            written[sel][off] = 1'b1;
        req_queue.push_back(r);
    endtask

    function automatic logic [7:0] pick_symbol();
        string codes = "ACGTRYMKSWHBVDN";
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return codes[$urandom_range(0, 3)];
            4, 5: return codes[$urandom_range(4, 13)];
            6: return "N";
            7: return codes[$urandom_range(0, 3)] + 8'd32;
            8: return 8'($urandom_range(0, 255));
            default: return codes[$urandom_range(0, 14)];
        endcase
    endfunction

    // A genome request with random content in the fields it does not use.
    task automatic push_genome(input logic [7:0] sym);
        push_req(OP_GENOME, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                 1'($urandom_range(0, 1)), sym);
    endtask

    task automatic load_probe(input int p, input int len);
        for (int j = 0; j < len; j++)
            push_req(OP_LOAD, 3'(p), 5'(j), j == len - 1, pick_symbol());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            threshold_reg = value;
        else
            nfilter_reg = value[1:0];
    endtask

    // Let every queued request and expected hit clear, then let the block settle.
    task automatic drain();
        while (req_queue.size() > 0 || in_ch.valid || hit_queue.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        string directed_probe;
        int p, len, off;
        threshold_reg = 7'd100;
        nfilter_reg = 2'd0;
        for (int i = 0; i < 8; i++)
            probe_len[i] = '0;
        longest = '0;
        clear_record();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lower-case fold, codes, a non-letter, N, unknown operation, new record.
        write_reg(CFG_THRESHOLD, 7'd50);
        write_reg(CFG_NFILTER, 7'd0);
        directed_probe = "acGt";
        foreach (directed_probe[i])
            push_req(OP_LOAD, 3'd0, 5'(i), i == 3, directed_probe[i]);
        push_req(OP_LOAD, 3'd7, 5'd0, 1'b0, "R");
        push_req(OP_LOAD, 3'd7, 5'd1, 1'b1, "-");
        directed_probe = "ACGTNACGNNNNx";
        foreach (directed_probe[i])
            push_genome(directed_probe[i]);
        push_req(OP_NONE, 3'd7, 5'd31, 1'b1, 8'hFF);
        push_req(OP_RECORD, 3'd0, 5'd0, 1'b0, 8'h00);
        push_genome("A");
        push_genome(8'hFF);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_reg(CFG_THRESHOLD, 7'd0);
                1: write_reg(CFG_THRESHOLD, 7'd127);
                2: write_reg(CFG_THRESHOLD, 7'd100);
                default: write_reg(CFG_THRESHOLD, 7'($urandom_range(0, 100)));
            endcase
            write_reg(CFG_NFILTER, 7'(phase % 4));
            gap_max = (phase % 3 == 1) ? 0 : 18;
            stall_max = (phase % 3 == 2) ? 0 : 18;
            if (phase == 4) begin
                load_probe(5, 32);
            end else begin
                repeat ($urandom_range(1, 2)) load_probe($urandom_range(0, 7),
                                                         $urandom_range(1, 6));
            end
            push_req(OP_RECORD, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), 1'b0,
                     8'h00);
            if (phase == 0)
                hold_grants <= hold_grants + 1;
            repeat (8) begin
                case ($urandom_range(0, 19))
                    0: push_req(OP_NONE, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                                1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                    1: push_req(OP_RECORD, 3'd0, 5'd0, 1'b0, 8'($urandom_range(0, 255)));
                    2: begin
                        // Rewrite a probe symbol mid-record; end it only where fully written.
                        p = $urandom_range(0, 7);
                        off = $urandom_range(0, 7);
                        len = 1;
                        for (int j = 0; j < off; j++)
                            if (!written[p][j])
                                len = 0;
                        push_req(OP_LOAD, 3'(p), 5'(off),
                                 len == 1 && $urandom_range(0, 1) != 0, pick_symbol());
                    end
                    default: push_genome(pick_symbol());
                endcase
            end
            drain();
        end

        if (error_count == 0 && hit_queue.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/ipwm_pkg.sv
hw/rtl/ipwm_if.sv
hw/rtl/ipwm_score.sv
hw/rtl/iupac_probe_window_matcher_core.sv
verif/tb.sv
